[design/byte_limited_packet_fifo_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the packet descriptor FIFO checker
// ----------------------------------------------------------------------------
`ifndef BYTE_LIMITED_PACKET_FIFO_ASSERT_SVH
`define BYTE_LIMITED_PACKET_FIFO_ASSERT_SVH

// same-cycle implication, off during reset
`define BLPF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("blpf assertion failed");

// next-cycle implication, off during reset
`define BLPF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("blpf assertion failed");

`endif

[design/blpf_pkg.sv]
// ----------------------------------------------------------------------------
// blpf_pkg
// Types and constants shared by the packet descriptor FIFO.
// ----------------------------------------------------------------------------
package blpf_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;

    localparam int unsigned LIMIT_W  = 32;
    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned DESC_W   = HANDLE_W + SIZE_W;
    localparam int unsigned CNT_OUT_W = 9;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1048576;

    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_LIMIT = 1'd1;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] TYPE_VIDEO = 2'd0;
    localparam logic [1:0] TYPE_AUDIO = 2'd1;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_GET,
        OP_FLUSH,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_VIDEO = 3'd1,
        ST_AUDIO = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic {
        BK_EXEC,
        BK_READ
    } back_state_t;

    typedef struct packed {
        op_t                 op;
        logic [1:0]          pkt_type;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [HANDLE_W-1:0]  handle;
        logic [SIZE_W-1:0]    size;
        logic [CNT_OUT_W-1:0] count;
        logic [LIMIT_W-1:0]   bytes;
    } result_t;

endpackage

[design/blpf_ram.sv]
// ----------------------------------------------------------------------------
// blpf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/blpf_front.sv]
// ----------------------------------------------------------------------------
// blpf_front
// Accepts input beats, decodes the operation and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module blpf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [1:0]                    pkt_type,
    input  logic [blpf_pkg::SIZE_W-1:0]   pkt_size,
    input  logic [blpf_pkg::HANDLE_W-1:0] pkt_handle,
    output logic                          q_valid,
    output blpf_pkg::item_t               q_item,
    input  logic                          q_pop
);
    import blpf_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      dec_item;

    always_comb
    begin
        dec_item.pkt_type = pkt_type;
        dec_item.size     = pkt_size;
        dec_item.handle   = pkt_handle;
        unique case (kind)
            KIND_PUT:   dec_item.op = OP_PUT;
            KIND_GET:   dec_item.op = OP_GET;
            KIND_FLUSH: dec_item.op = OP_FLUSH;
            KIND_NOP:   dec_item.op = OP_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

[design/blpf_back.sv]
// ----------------------------------------------------------------------------
// blpf_back
// Executes queued operations against the descriptor ring, keeps the packet
// and byte counts and holds the result in an output register.
// ----------------------------------------------------------------------------
module blpf_back #(
    parameter int unsigned DEPTH = blpf_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  blpf_pkg::item_t              q_item,
    output logic                         q_pop,
    input  logic [blpf_pkg::LIMIT_W-1:0] video_limit,
    input  logic [blpf_pkg::LIMIT_W-1:0] audio_limit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output blpf_pkg::result_t            out_res
);
    import blpf_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    back_state_t          state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [LIMIT_W-1:0]   bytes_reg, bytes_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;

    logic                 ram_we, ram_re;
    logic [DESC_W-1:0]    ram_rdata;
    logic [SIZE_W-1:0]    rd_size;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [LIMIT_W:0]     put_sum;
    logic [LIMIT_W-1:0]   put_bytes;
    logic                 slot_free;
    logic                 load;
    status_t              ld_status;
    logic [HANDLE_W-1:0]  ld_handle;
    logic [SIZE_W-1:0]    ld_size;

    blpf_ram #(
        .WIDTH (DESC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({q_item.handle, q_item.size}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign rd_handle = ram_rdata[DESC_W-1:SIZE_W];
    assign rd_size   = ram_rdata[SIZE_W-1:0];
    assign put_sum   = {1'b0, bytes_reg} + {{(LIMIT_W + 1 - SIZE_W){1'b0}}, q_item.size};
    assign put_bytes = put_sum[LIMIT_W] ? '1 : put_sum[LIMIT_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        q_pop          = 1'b0;
        load           = 1'b0;
        ld_status      = ST_OK;
        ld_handle      = '0;
        ld_size        = '0;

        unique case (state_reg)
            BK_EXEC:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.op)
                        OP_PUT:
                        begin
                            load = 1'b1;
                            priority if (q_item.pkt_type == TYPE_VIDEO
                                         && bytes_reg >= video_limit)
                            begin
                                ld_status = ST_VIDEO;
                            end
                            else if (q_item.pkt_type == TYPE_AUDIO
                                     && bytes_reg >= audio_limit)
                            begin
                                ld_status = ST_AUDIO;
                            end
                            else if (count_reg == FULL_CNT)
                            begin
                                ld_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                                bytes_next = put_bytes;
                            end
                        end
                        OP_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = BK_READ;
                            end
                        end
                        OP_FLUSH:
                        begin
                            load       = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            bytes_next = '0;
                        end
                        OP_NOP:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                // output slot is always free here: the get was popped only when it was
                load       = 1'b1;
                ld_handle  = rd_handle;
                ld_size    = rd_size;
                head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    bytes_next = '0;
                end
                else if (bytes_reg >= {{(LIMIT_W - SIZE_W){1'b0}}, rd_size})
                begin
                    bytes_next = bytes_reg - {{(LIMIT_W - SIZE_W){1'b0}}, rd_size};
                end
                else
                begin
                    bytes_next = '0;
                end
                state_next = BK_EXEC;
            end
        endcase

        res_next = res_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            res_next.status = ld_status;
            res_next.handle = ld_handle;
            res_next.size   = ld_size;
            res_next.count  = CNT_OUT_W'(count_next);
            res_next.bytes  = bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

[design/byte_limited_packet_fifo.sv]
// ----------------------------------------------------------------------------
// byte_limited_packet_fifo
// Ring of packet descriptors with packet and byte counts and byte-limit
// admission for video and audio puts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one operation per beat: put,
// get, flush or no-op, with packet type, size and handle for puts.
// Output channel (out_valid/out_ready) returns exactly one result beat per
// input beat, in order: status, popped handle and size, and the packet and
// byte counts after the operation.
// Put, flush and no-op results pass through the front-end queue and the
// output register; a non-empty get also takes the registered RAM read.
// Throughput: one put, flush or no-op per cycle while the receiver takes
// results; the back end takes no new beat while a non-empty get waits for
// the RAM read. A two-entry queue separates the front end from the back
// end, and an output register holds a finished result while the next beat
// is taken. If the receiver stalls, the result holds, the queue fills and
// in_ready drops. Reset empties the ring and the queue and loads both
// limits with 1048576; descriptor storage is not cleared. The user is to
// write limits through cfg_we/cfg_index/cfg_data while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module byte_limited_packet_fifo #(
    parameter int unsigned DEPTH = blpf_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [blpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blpf_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     kind,
    input  logic [1:0]                     pkt_type,
    input  logic [blpf_pkg::SIZE_W-1:0]    pkt_size,
    input  logic [blpf_pkg::HANDLE_W-1:0]  pkt_handle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [blpf_pkg::HANDLE_W-1:0]  out_handle,
    output logic [blpf_pkg::SIZE_W-1:0]    out_size,
    output logic [blpf_pkg::CNT_OUT_W-1:0] packet_count,
    output logic [blpf_pkg::LIMIT_W-1:0]   byte_total
);
    import blpf_pkg::*;

    logic [LIMIT_W-1:0] video_limit_reg;
    logic [LIMIT_W-1:0] audio_limit_reg;
    logic               q_valid;
    logic               q_pop;
    item_t              q_item;
    result_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_limit_reg <= LIMIT_RESET;
            audio_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIDEO_LIMIT: video_limit_reg <= cfg_data;
                REG_AUDIO_LIMIT: audio_limit_reg <= cfg_data;
            endcase
        end
    end

    blpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .pkt_type   (pkt_type),
        .pkt_size   (pkt_size),
        .pkt_handle (pkt_handle),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    blpf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .video_limit (video_limit_reg),
        .audio_limit (audio_limit_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (res)
    );

    assign status       = res.status;
    assign out_handle   = res.handle;
    assign out_size     = res.size;
    assign packet_count = res.count;
    assign byte_total   = res.bytes;

endmodule

[design/blpf_checker.sv]
// ----------------------------------------------------------------------------
// blpf_checker
// Port-level checks on the result channel of the descriptor FIFO.
// ----------------------------------------------------------------------------
`include "byte_limited_packet_fifo_assert.svh"

module blpf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [2:0]                     status,
    input logic [blpf_pkg::HANDLE_W-1:0]  out_handle,
    input logic [blpf_pkg::SIZE_W-1:0]    out_size,
    input logic [blpf_pkg::CNT_OUT_W-1:0] packet_count,
    input logic [blpf_pkg::LIMIT_W-1:0]   byte_total
);
    import blpf_pkg::*;

    // stalled result beat holds
    `BLPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_handle) && $stable(out_size) && $stable(byte_total))

    // empty get reports an empty ring and no descriptor
    `BLPF_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && status == ST_EMPTY, packet_count == '0 && byte_total == '0 && out_handle == '0 && out_size == '0)

    // any refusal carries no descriptor
    `BLPF_ASSERT_IMP(a_refused_no_desc, clk, rst_n, out_valid && (status == ST_VIDEO || status == ST_AUDIO || status == ST_FULL), out_handle == '0 && out_size == '0)

endmodule

bind byte_limited_packet_fifo blpf_checker u_blpf_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: packet descriptor FIFO with byte-limit admission
// Runs a short directed table (empty get, no-op, flush, video and audio
// refusal, field extremes), then random phases of put/get/flush/no-op beats
// under several limit settings. Each phase starts only once all results are
// back. An in-bench model of the ring and its counters predicts every
// result, and results are checked field by field in order. Both channels
// stall at random.
// ----------------------------------------------------------------------------
module tb;
    import blpf_pkg::*;

    localparam int unsigned RING_SLOTS = DEPTH_DEFAULT;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]          kind;
        logic [1:0]          ptype;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
        bit                  known;
        result_t             want;
    } dir_row_t;

    localparam result_t NO_WANT = '0;
    localparam int unsigned DIR_ROWS = 23;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LIMIT_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             kind;
    logic [1:0]             pkt_type;
    logic [SIZE_W-1:0]      pkt_size;
    logic [HANDLE_W-1:0]    pkt_handle;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             status;
    logic [HANDLE_W-1:0]    out_handle;
    logic [SIZE_W-1:0]      out_size;
    logic [CNT_OUT_W-1:0]   packet_count;
    logic [LIMIT_W-1:0]     byte_total;

    // model of the ring and its counters
    logic [HANDLE_W-1:0]    slot_handle [RING_SLOTS];
    logic [SIZE_W-1:0]      slot_size [RING_SLOTS];
    int unsigned            head_idx;
    int unsigned            tail_idx;
    int unsigned            held_pkts;
    logic [LIMIT_W-1:0]     held_bytes;
    logic [LIMIT_W-1:0]     video_cap;
    logic [LIMIT_W-1:0]     audio_cap;

    result_t                pending_results [$];
    int unsigned            mismatches;
    int unsigned            quiet_cycles;
    int unsigned            src_calm;
    int unsigned            sink_hold;
    int unsigned            sink_calm;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{KIND_GET,   2'd0, 24'h0,      32'h0,        1'b1,
          '{ST_EMPTY, 32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_NOP,   2'd3, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_FLUSH, 2'd0, 24'h0,      32'h0,        1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_PUT,   TYPE_VIDEO, 24'h0, 32'h0,       1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd1, 32'h0}},
        '{KIND_PUT,   TYPE_AUDIO, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd2, 32'h00FFFFFF}},
        '{KIND_PUT,   TYPE_VIDEO, 24'h000010, 32'h12345678, 1'b1,
          '{ST_VIDEO, 32'h0, 24'h0, 9'd2, 32'h00FFFFFF}},
        '{KIND_PUT,   TYPE_AUDIO, 24'h000020, 32'h87654321, 1'b1,
          '{ST_AUDIO, 32'h0, 24'h0, 9'd2, 32'h00FFFFFF}},
        '{KIND_PUT,   2'd2, 24'hFFFFFF, 32'hA5A5A5A5, 1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd3, 32'h01FFFFFE}},
        '{KIND_PUT,   2'd3, 24'h000001, 32'h5A5A5A5A, 1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd4, 32'h01FFFFFF}},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0,        1'b1,
          '{ST_EMPTY, 32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_PUT,   2'd2, 24'h800000, 32'h0F0F0F0F, 1'b0, NO_WANT},
        '{KIND_PUT,   2'd3, 24'h7FFFFF, 32'hF0F0F0F0, 1'b0, NO_WANT},
        '{KIND_FLUSH, 2'd0, 24'h0, 32'h0,        1'b1,
          '{ST_OK,    32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_GET,   2'd0, 24'h0, 32'h0,        1'b1,
          '{ST_EMPTY, 32'h0, 24'h0, 9'd0, 32'h0}},
        '{KIND_PUT,   TYPE_VIDEO, 24'd100, 32'h00000001, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT},
        '{KIND_PUT,   2'd2, 24'd5, 32'hC3C3C3C3, 1'b0, NO_WANT},
        '{KIND_NOP,   2'd1, 24'h123456, 32'h3C3C3C3C, 1'b0, NO_WANT},
        '{KIND_GET,   2'd0, 24'h0, 32'h0, 1'b0, NO_WANT}
    };

    byte_limited_packet_fifo u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pkt_type     (pkt_type),
        .pkt_size     (pkt_size),
        .pkt_handle   (pkt_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_handle   (out_handle),
        .out_size     (out_size),
        .packet_count (packet_count),
        .byte_total   (byte_total)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic result_t fifo_step(logic [1:0] k, logic [1:0] t,
                                          logic [SIZE_W-1:0] sz,
                                          logic [HANDLE_W-1:0] h);
        result_t r;
        logic [LIMIT_W:0] sum;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_PUT:
            begin
                if (t == TYPE_VIDEO && held_bytes >= video_cap)
                    r.status = ST_VIDEO;
                else if (t == TYPE_AUDIO && held_bytes >= audio_cap)
                    r.status = ST_AUDIO;
                else if (held_pkts >= RING_SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    slot_handle[tail_idx] = h;
                    slot_size[tail_idx] = sz;
                    tail_idx = (tail_idx + 1 >= RING_SLOTS) ? 0 : tail_idx + 1;
                    held_pkts++;
                    sum = {1'b0, held_bytes} + sz;
                    held_bytes = sum[LIMIT_W] ? '1 : sum[LIMIT_W-1:0];
                end
            end
            KIND_GET:
            begin
                if (held_pkts == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.handle = slot_handle[head_idx];
                    r.size = slot_size[head_idx];
                    head_idx = (head_idx + 1 >= RING_SLOTS) ? 0 : head_idx + 1;
                    held_pkts--;
                    held_bytes = (held_bytes >= r.size) ? held_bytes - r.size : '0;
                    if (held_pkts == 0)
                        held_bytes = '0;
                end
            end
            KIND_FLUSH:
            begin
                head_idx = 0;
                tail_idx = 0;
                held_pkts = 0;
                held_bytes = '0;
            end
            default:
            begin
            end
        endcase
        r.count = held_pkts[CNT_OUT_W-1:0];
        r.bytes = held_bytes;
        return r;
    endfunction

    function automatic int unsigned src_gap();
        int unsigned pick;
        if (src_calm > 0)
        begin
            src_calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2)
            src_calm = $urandom_range(30, 120);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 32'h0040_0000);
        return $urandom;
    endfunction

    task automatic issue(logic [1:0] k, logic [1:0] t, logic [SIZE_W-1:0] sz,
                         logic [HANDLE_W-1:0] h, bit known, result_t want);
        int unsigned gap;
        result_t pred;
        gap = src_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        pkt_type   <= t;
        pkt_size   <= sz;
        pkt_handle <= h;
        do
            @(posedge clk);
        while (!in_ready);
        pred = fifo_step(k, t, sz, h);
        pending_results.push_back(known ? want : pred);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] v, logic [LIMIT_W-1:0] a);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VIDEO_LIMIT;
        cfg_data  <= v;
        @(posedge clk);
        cfg_index <= REG_AUDIO_LIMIT;
        cfg_data  <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        video_cap = v;
        audio_cap = a;
    endtask

    task automatic report(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none actual status %h",
                         $time, status);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                report("status", 32'(exp_r.status), 32'(status));
                report("out_handle", exp_r.handle, out_handle);
                report("out_size", 32'(exp_r.size), 32'(out_size));
                report("packet_count", 32'(exp_r.count), 32'(packet_count));
                report("byte_total", exp_r.bytes, byte_total);
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        int unsigned pick;
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (sink_calm > 0)
                sink_calm <= sink_calm - 1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    sink_hold <= $urandom_range(1, 3);
                else if (pick < 28)
                    sink_hold <= $urandom_range(20, 50);
                else if (pick < 30)
                    sink_calm <= $urandom_range(50, 200);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("byte_limited_packet_fifo: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned ph_items [7];
        int unsigned ph_put [7];
        int unsigned ph_flush [7];
        logic [LIMIT_W-1:0] v_lim;
        logic [LIMIT_W-1:0] a_lim;
        logic [1:0] k;
        logic [SIZE_W-1:0] sz;
        int unsigned pick;

        ph_items = '{200, 450, 250, 200, 250, 300, 250};
        ph_put   = '{50, 90, 50, 25, 50, 85, 50};
        ph_flush = '{2, 0, 2, 3, 2, 0, 2};

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        kind       <= KIND_NOP;
        pkt_type   <= '0;
        pkt_size   <= '0;
        pkt_handle <= '0;
        out_ready  <= 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        src_calm = 0;
        sink_hold = 0;
        sink_calm = 0;
        head_idx = 0;
        tail_idx = 0;
        held_pkts = 0;
        held_bytes = '0;
        video_cap = LIMIT_RESET;
        audio_cap = LIMIT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue(dir_rows[i].kind, dir_rows[i].ptype, dir_rows[i].size,
                  dir_rows[i].handle, dir_rows[i].known, dir_rows[i].want);

        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            case (p)
                0: begin v_lim = '0; a_lim = '0; end
                1: begin v_lim = '1; a_lim = '1; end
                3: begin v_lim = '1; a_lim = '0; end
                5: begin v_lim = '0; a_lim = '1; end
                default: begin v_lim = rand_limit(); a_lim = rand_limit(); end
            endcase
            set_limits(v_lim, a_lim);
            for (int n = 0; n < ph_items[p]; n++)
            begin
                if (p == 4 && n == ph_items[p] / 2)
                    wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < ph_put[p])
                    k = KIND_PUT;
                else if (pick < ph_put[p] + ph_flush[p])
                    k = KIND_FLUSH;
                else if (pick < ph_put[p] + ph_flush[p] + 2)
                    k = KIND_NOP;
                else
                    k = KIND_GET;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    sz = SIZE_W'($urandom_range(0, 4095));
                else if (pick < 9)
                    sz = SIZE_W'($urandom_range(0, 32'h0010_0000));
                else
                    sz = SIZE_W'($urandom);
                issue(k, 2'($urandom_range(0, 3)), sz, $urandom, 1'b0, NO_WANT);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("byte_limited_packet_fifo: match");
        else
            $display("byte_limited_packet_fifo: mismatch");
        $finish;
    end

endmodule
